// ===== sv/rhsv_pkg.sv =====
package rhsv_pkg;

  // Field widths of the pixel and the result.
  localparam int unsigned ChW     = 8;
  localparam int unsigned HueW    = 15;
  localparam int unsigned SatW    = 16;
  localparam int unsigned HueIntW = 9;   // whole degrees stay below 512
  localparam int unsigned NumW    = 17;  // hue numerator stays below 360 * 255

  // Default number of fraction bits of the hue.
  localparam int unsigned HueFracBitsDef = 6;

  // Saturation is delta / max scaled to Q1.15.
  localparam int unsigned SatFracBits = 15;

  // Degree constants of the hue sectors.
  localparam int unsigned DegSector = 60;
  localparam int unsigned DegGreen  = 120;
  localparam int unsigned DegBlue   = 240;
  localparam int unsigned DegFull   = 360;

  // Quotient bits resolved by one divider stage.
  localparam int unsigned StepsPerStage = 4;

  // Which channel is the maximum, and whether the red sector wraps.
  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2,
    SecWrap  = 2'd3
  } sector_e;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } rhsv_pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [ChW-1:0]  brightness;
  } rhsv_hsv_t;

  // Values that ride along the divider pipeline.
  typedef struct packed {
    logic           gray;
    logic [ChW-1:0] delta;
    logic [ChW-1:0] maxv;
  } rhsv_side_t;

  // Quotient bits of both divisions, rounded up to whole divider stages.
  function automatic int unsigned div_steps(input int unsigned frac_bits);
    int unsigned need;
    need = HueIntW + frac_bits;
    if (need < SatW) begin
      need = SatW;
    end
    return ((need + StepsPerStage - 1) / StepsPerStage) * StepsPerStage;
  endfunction

endpackage

// ===== sv/rhsv_prep.sv =====
module rhsv_prep #(
  parameter int unsigned HUE_FRAC_BITS = rhsv_pkg::HueFracBitsDef,
  parameter int unsigned NUM_STEPS     = rhsv_pkg::div_steps(HUE_FRAC_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  rhsv_pkg::rhsv_pixel_t        pix_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [NUM_STEPS+7:0]         hue_acc_o,
  output logic [NUM_STEPS+7:0]         sat_acc_o,
  output rhsv_pkg::rhsv_side_t         side_o
);

  localparam int unsigned AccW = NUM_STEPS + rhsv_pkg::ChW;

  // First stage registers: extremes, sector and channel difference.
  logic                       a_valid_q;
  logic [rhsv_pkg::ChW-1:0]   a_max_q, a_max_d;
  logic [rhsv_pkg::ChW-1:0]   a_delta_q, a_delta_d;
  logic [rhsv_pkg::ChW-1:0]   a_diff_q, a_diff_d;
  logic                       a_neg_q, a_neg_d;
  logic                       a_gray_q, a_gray_d;
  rhsv_pkg::sector_e          a_sec_q, a_sec_d;

  // Second stage registers: dividends ready for the divider.
  logic                       b_valid_q;
  logic [AccW-1:0]            b_hue_q, b_hue_d;
  logic [AccW-1:0]            b_sat_q, b_sat_d;
  rhsv_pkg::rhsv_side_t       b_side_q;

  logic                       a_stall, b_stall;
  logic [rhsv_pkg::ChW-1:0]   mn;
  logic [rhsv_pkg::NumW-1:0]  base, offs, num;

  // A stage holds only when it has a beat and the next stage holds.
  assign b_stall = b_valid_q && stall_i;
  assign a_stall = a_valid_q && b_stall;
  assign stall_o = a_stall;

  // Maximum with ties to red then green, and the signed channel difference.
  always_comb begin
    a_gray_d = (pix_i.red == pix_i.green) && (pix_i.green == pix_i.blue);
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      a_max_d = pix_i.red;
      a_neg_d = pix_i.green < pix_i.blue;
      a_diff_d = a_neg_d ? pix_i.blue - pix_i.green : pix_i.green - pix_i.blue;
      a_sec_d = a_neg_d ? rhsv_pkg::SecWrap : rhsv_pkg::SecRed;
    end else if (pix_i.green >= pix_i.blue) begin
      a_max_d = pix_i.green;
      a_neg_d = pix_i.blue < pix_i.red;
      a_diff_d = a_neg_d ? pix_i.red - pix_i.blue : pix_i.blue - pix_i.red;
      a_sec_d = rhsv_pkg::SecGreen;
    end else begin
      a_max_d = pix_i.blue;
      a_neg_d = pix_i.red < pix_i.green;
      a_diff_d = a_neg_d ? pix_i.green - pix_i.red : pix_i.red - pix_i.green;
      a_sec_d = rhsv_pkg::SecBlue;
    end
    mn = pix_i.red;
    if (pix_i.green < mn) begin
      mn = pix_i.green;
    end
    if (pix_i.blue < mn) begin
      mn = pix_i.blue;
    end
    a_delta_d = a_max_d - mn;
  end

  // Hue numerator: sector offset times delta, plus or minus 60 times the difference.
  always_comb begin
    case (a_sec_q)
      rhsv_pkg::SecGreen: base = rhsv_pkg::NumW'(a_delta_q) * rhsv_pkg::NumW'(rhsv_pkg::DegGreen);
      rhsv_pkg::SecBlue:  base = rhsv_pkg::NumW'(a_delta_q) * rhsv_pkg::NumW'(rhsv_pkg::DegBlue);
      rhsv_pkg::SecWrap:  base = rhsv_pkg::NumW'(a_delta_q) * rhsv_pkg::NumW'(rhsv_pkg::DegFull);
      default:            base = '0;
    endcase
    offs = rhsv_pkg::NumW'(a_diff_q) * rhsv_pkg::NumW'(rhsv_pkg::DegSector);
    num = a_neg_q ? base - offs : base + offs;
    b_hue_d = AccW'(num) << HUE_FRAC_BITS;
    b_sat_d = AccW'(a_delta_q) << rhsv_pkg::SatFracBits;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (!a_stall) begin
        a_valid_q <= valid_i;
      end
      if (!b_stall) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // Payload of the first stage.
  always_ff @(posedge clk_i) begin
    if (!a_stall && valid_i) begin
      a_max_q   <= a_max_d;
      a_delta_q <= a_delta_d;
      a_diff_q  <= a_diff_d;
      a_neg_q   <= a_neg_d;
      a_gray_q  <= a_gray_d;
      a_sec_q   <= a_sec_d;
    end
  end

  // Payload of the second stage.
  always_ff @(posedge clk_i) begin
    if (!b_stall && a_valid_q) begin
      b_hue_q        <= b_hue_d;
      b_sat_q        <= b_sat_d;
      b_side_q.gray  <= a_gray_q;
      b_side_q.delta <= a_delta_q;
      b_side_q.maxv  <= a_max_q;
    end
  end

  assign valid_o   = b_valid_q;
  assign hue_acc_o = b_hue_q;
  assign sat_acc_o = b_sat_q;
  assign side_o    = b_side_q;

endmodule

// ===== sv/rhsv_div_stage.sv =====
module rhsv_div_stage #(
  parameter int unsigned NUM_STEPS = rhsv_pkg::div_steps(rhsv_pkg::HueFracBitsDef)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [NUM_STEPS+7:0]     hue_acc_i,
  input  logic [NUM_STEPS+7:0]     sat_acc_i,
  input  rhsv_pkg::rhsv_side_t     side_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [NUM_STEPS+7:0]     hue_acc_o,
  output logic [NUM_STEPS+7:0]     sat_acc_o,
  output rhsv_pkg::rhsv_side_t     side_o
);

  localparam int unsigned AccW = NUM_STEPS + rhsv_pkg::ChW;

  logic                  valid_q;
  logic [AccW-1:0]       hue_q, hue_d;
  logic [AccW-1:0]       sat_q, sat_d;
  rhsv_pkg::rhsv_side_t  side_q;

  // StepsPerStage restoring division steps. The accumulator holds the partial
  // remainder on top and the dividend bits still to come below; quotient
  // bits shift in at the bottom.
  function automatic logic [AccW-1:0] div_steps_f(input logic [AccW-1:0] acc,
                                                  input logic [rhsv_pkg::ChW-1:0] dv);
    logic [AccW-1:0]           a;
    logic [rhsv_pkg::ChW:0]    t;
    logic [rhsv_pkg::ChW:0]    diff;
    a = acc;
    for (int k = 0; k < int'(rhsv_pkg::StepsPerStage); k++) begin
      t = a[AccW-1:NUM_STEPS-1];
      diff = t - {1'b0, dv};
      if (t >= {1'b0, dv}) begin
        a = {diff[rhsv_pkg::ChW-1:0], a[NUM_STEPS-2:0], 1'b1};
      end else begin
        a = {a[AccW-2:0], 1'b0};
      end
    end
    return a;
  endfunction

  assign stall_o = valid_q && stall_i;

  // Hue divides by delta, saturation by the maximum.
  always_comb begin
    hue_d = div_steps_f(hue_acc_i, side_i.delta);
    sat_d = div_steps_f(sat_acc_i, side_i.maxv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      hue_q  <= hue_d;
      sat_q  <= sat_d;
      side_q <= side_i;
    end
  end

  assign valid_o   = valid_q;
  assign hue_acc_o = hue_q;
  assign sat_acc_o = sat_q;
  assign side_o    = side_q;

endmodule

// ===== sv/rgb_to_hsv_converter_unit.sv =====
// RGB to HSV converter, one pixel per beat.
//
// Input channel: in_valid_i / in_stall_o with one RGB pixel of 8-bit channels in in_data_i.
// Output channel: out_valid_o / out_stall_i with hue (degrees, Q9.6 by default),
// saturation (Q1.15) and brightness (the largest channel) in out_data_o.
// A beat moves on a rising edge with valid high and stall low.
//
// The front end first finds the maximum, minimum, sector and channel difference,
// then the hue numerator and dividends; the two divisions then run side by
// side through a chain of restoring divider stages, four quotient bits each.
// The block takes one pixel per cycle while the receiver does not stall.
//
// Reset clears all valid bits; the pipeline comes up empty and accepts at once.
// When the receiver stalls, the held result stays on the port and each stage
// behind it keeps filling until it holds a beat of its own; in_stall_o rises
// only once every stage is full.
module rgb_to_hsv_converter_unit #(
  parameter int unsigned HUE_FRAC_BITS = rhsv_pkg::HueFracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rhsv_pkg::rhsv_pixel_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rhsv_pkg::rhsv_hsv_t    out_data_o
);

  localparam int unsigned NumSteps  = rhsv_pkg::div_steps(HUE_FRAC_BITS);
  localparam int unsigned NumStages = NumSteps / rhsv_pkg::StepsPerStage;
  localparam int unsigned AccW      = NumSteps + rhsv_pkg::ChW;

  // Links between stages; index 0 is the output of the front end.
  logic                  vld [NumStages+1];
  logic                  stl [NumStages+1];
  logic [AccW-1:0]       hacc [NumStages+1];
  logic [AccW-1:0]       sacc [NumStages+1];
  rhsv_pkg::rhsv_side_t  side [NumStages+1];

  rhsv_prep #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .NUM_STEPS     (NumSteps)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .pix_i     (in_data_i),
    .valid_o   (vld[0]),
    .stall_i   (stl[0]),
    .hue_acc_o (hacc[0]),
    .sat_acc_o (sacc[0]),
    .side_o    (side[0])
  );

  // Divider chain.
  for (genvar s = 0; s < NumStages; s++) begin : g_div
    rhsv_div_stage #(
      .NUM_STEPS (NumSteps)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[s]),
      .stall_o   (stl[s]),
      .hue_acc_i (hacc[s]),
      .sat_acc_i (sacc[s]),
      .side_i    (side[s]),
      .valid_o   (vld[s+1]),
      .stall_i   (stl[s+1]),
      .hue_acc_o (hacc[s+1]),
      .sat_acc_o (sacc[s+1]),
      .side_o    (side[s+1])
    );
  end

  assign stl[NumStages] = out_stall_i;
  assign out_valid_o    = vld[NumStages];

  // Quotients sit in the low accumulator bits; gray pixels give zero hue and saturation.
  always_comb begin
    out_data_o.hue        = side[NumStages].gray ? '0 : hacc[NumStages][rhsv_pkg::HueW-1:0];
    out_data_o.saturation = side[NumStages].gray ? '0 : sacc[NumStages][rhsv_pkg::SatW-1:0];
    out_data_o.brightness = side[NumStages].maxv;
  end

endmodule

// ===== sv/rhsv_checker.sv =====
module rhsv_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input rhsv_pkg::rhsv_pixel_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input rhsv_pkg::rhsv_hsv_t    out_data_o
);

  // A stalled pixel beat stays offered and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("pixel beat changed while stalled");

  // A stalled result beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Saturation never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.saturation <= 16'd32768)
    else $error("saturation above 1.0");

  // Zero saturation only comes from a gray pixel, whose hue is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturation == '0 |-> out_data_o.hue == '0)
    else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_unit rhsv_checker u_rhsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/tb_rgb_to_hsv_converter_unit.sv =====
module tb_rgb_to_hsv_converter_unit;
  import rhsv_pkg::*;

  localparam int unsigned HueFrac    = HueFracBitsDef;
  localparam int unsigned Latency    = 2 + div_steps(HueFrac) / StepsPerStage;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PrintCap   = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  rhsv_pixel_t in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rhsv_hsv_t   out_data_o;

  // Pixels waiting to be offered, and the HSV beats still owed by the block.
  rhsv_pixel_t pixel_queue[$];
  rhsv_hsv_t   hsv_expected[$];

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  logic        hold_go     = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  rgb_to_hsv_converter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Expected HSV of one pixel, hue truncated to HueFrac fraction bits.
  function automatic rhsv_hsv_t hsv_of(input rhsv_pixel_t px);
    int        r;
    int        g;
    int        b;
    int        top;
    int        bottom;
    int        spread;
    longint    deg_num;
    longint    hue_full;
    longint    sat_full;
    sector_e   sector;
    rhsv_hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    res = '0;
    // A gray pixel has no hue and no saturation.
    if (r == g && g == b) begin
      res.brightness = px.red;
      return res;
    end
    top    = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
    bottom = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    spread = top - bottom;
    // Ties for the maximum go to red first, then green.
    if (top == r) begin
      sector = (g >= b) ? SecRed : SecWrap;
    end else if (top == g) begin
      sector = SecGreen;
    end else begin
      sector = SecBlue;
    end
    case (sector)
      SecRed: begin
        deg_num = longint'(DegSector) * (g - b);
      end
      SecWrap: begin
        // A negative red-sector hue wraps into the top of the circle.
        deg_num = longint'(DegFull) * spread + longint'(DegSector) * (g - b);
      end
      SecGreen: begin
        deg_num = longint'(DegGreen) * spread + longint'(DegSector) * (b - r);
      end
      default: begin
        deg_num = longint'(DegBlue) * spread + longint'(DegSector) * (r - g);
      end
    endcase
    hue_full = (deg_num << HueFrac) / spread;
    sat_full = (longint'(spread) << SatFracBits) / top;
    res.hue        = hue_full[HueW-1:0];
    res.saturation = sat_full[SatW-1:0];
    res.brightness = top[ChW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintCap) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  task automatic push_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
    rhsv_pixel_t px;
    px.red   = r[ChW-1:0];
    px.green = g[ChW-1:0];
    px.blue  = b[ChW-1:0];
    pixel_queue.push_back(px);
  endtask

  // Random pixels, weighted toward gray, tied and nearly gray ones.
  task automatic queue_random(input int unsigned count);
    int unsigned kind;
    int unsigned base;
    int unsigned low;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      base = $urandom_range(255);
      low  = $urandom_range(base);
      if (kind < 55) begin
        push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end else if (kind < 63) begin
        push_pixel(base, base, base);
      end else if (kind < 80) begin
        case ($urandom_range(2))
          0:       push_pixel(base, base, low);
          1:       push_pixel(base, low, base);
          default: push_pixel(low, base, base);
        endcase
      end else begin
        base = $urandom_range(252);
        push_pixel(base + $urandom_range(3), base + $urandom_range(3),
                   base + $urandom_range(3));
      end
    end
  endtask

  // Let the sender run dry and every owed result come back.
  task automatic drain();
    while (pixel_queue.size() != 0 || in_valid_i || hsv_expected.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: a stalled beat holds; otherwise offer the next pixel or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted apart from the random stalls.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted pixel, check each accepted result.
  always @(posedge clk_i) begin
    rhsv_hsv_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        hsv_expected.push_back(hsv_of(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = hsv_expected.pop_front();
          if (out_data_o.hue !== want.hue) begin
            report_mismatch($sformatf("hue got %0d want %0d", out_data_o.hue, want.hue));
          end
          if (out_data_o.saturation !== want.saturation) begin
            report_mismatch($sformatf("saturation got %0d want %0d",
                                      out_data_o.saturation, want.saturation));
          end
          if (out_data_o.brightness !== want.brightness) begin
            report_mismatch($sformatf("brightness got %0d want %0d",
                                      out_data_o.brightness, want.brightness));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_rgb_to_hsv_converter_unit failed");
      $finish;
    end
  end

  // Stimulus phases.
  initial begin
    // Directed pixels: extremes, gray, each sector, ties and the red wrap.
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(128, 128, 128);
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 0);
    push_pixel(0, 0, 255);
    push_pixel(255, 255, 0);
    push_pixel(0, 255, 255);
    push_pixel(255, 0, 255);
    push_pixel(255, 0, 1);
    push_pixel(200, 100, 100);
    push_pixel(40, 200, 90);
    push_pixel(90, 200, 40);
    push_pixel(150, 20, 230);
    push_pixel(20, 150, 230);
    push_pixel(1, 0, 0);
    push_pixel(0, 1, 1);
    push_pixel(255, 254, 254);
    push_pixel(1, 1, 0);
    push_pixel(170, 85, 255);
    push_pixel(85, 170, 85);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // No idling on either side.
    queue_random(350);
    drain();
    // Sparse sender.
    idle_pct = 82;
    queue_random(300);
    drain();
    // Heavily stalling receiver.
    idle_pct  = 0;
    stall_pct = 82;
    queue_random(300);
    drain();
    // Both sides idle now and then.
    idle_pct  = 35;
    stall_pct = 35;
    queue_random(400);
    drain();
    // Receiver holds off while the sender keeps offering, so the block fills.
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    queue_random(200);
    drain();
    idle_pct  = 35;
    stall_pct = 35;
    queue_random(130);
    drain();

    // Quiet tail to catch stray result beats.
    idle_pct  = 0;
    stall_pct = 0;
    repeat (Latency * 4) @(posedge clk_i);
    if (error_count == 0 && hsv_expected.size() == 0) begin
      $display("tb_rgb_to_hsv_converter_unit passed");
    end else begin
      $display("tb_rgb_to_hsv_converter_unit failed");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_converter_unit.f =====
sv/rhsv_pkg.sv
sv/rhsv_prep.sv
sv/rhsv_div_stage.sv
sv/rgb_to_hsv_converter_unit.sv
sv/rhsv_checker.sv
bench/tb_rgb_to_hsv_converter_unit.sv
